/* src/sld_pkg.sv */
// ----------------------------------------------------------------------------
// sld_pkg
// shared types and phase codes for the sync/length frame deframer
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int unsigned PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ID    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TRAIL = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PEND  = 3'd6;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] REG_TRAILER_BYTES = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST    = 8'h7E;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'h7F;
    localparam logic [2:0] TRAILER_BYTES_RST = 3'd3;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [2:0] trailer_bytes;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         current_id;
        logic [7:0]         payload_length;
        logic [7:0]         position;
    } state_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] frame_id;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last;
    } result_t;

endpackage

/* src/sld_step.sv */
// ----------------------------------------------------------------------------
// sld_step
// next-state and result logic for one received byte
// ----------------------------------------------------------------------------
module sld_step (
    input  sld_pkg::cfg_t    cfg,
    input  sld_pkg::state_t  cur,
    input  logic [7:0]       rx_byte,
    output sld_pkg::state_t  nxt,
    output sld_pkg::result_t res
);
    import sld_pkg::*;

    logic       fin;
    logic [7:0] pos_inc;
    logic       trail_done;

    assign pos_inc    = cur.position + 8'd1;
    assign fin        = (pos_inc == cur.payload_length) || (cur.position >= cur.payload_length);
    assign trail_done = pos_inc >= {5'd0, cfg.trailer_bytes};

    always_comb
    begin
        nxt              = cur;
        res.valid        = 1'b0;
        res.kind         = KIND_COMPLETE;
        res.frame_id     = cur.current_id;
        res.payload_byte = 8'd0;
        res.byte_index   = cur.payload_length;
        res.last         = 1'b0;
        unique case (cur.phase)
            PH_HUNT2:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    nxt.phase = PH_LEN;
                end
                else if (rx_byte == cfg.sync_first)
                begin
                    nxt.phase = PH_HUNT2;
                end
                else
                begin
                    nxt.phase = PH_HUNT1;
                end
            end
            PH_LEN:
            begin
                nxt.payload_length = rx_byte;
                nxt.phase          = PH_ID;
            end
            PH_ID:
            begin
                nxt.current_id = rx_byte;
                nxt.position   = 8'd0;
                res.frame_id   = rx_byte;
                if (cur.payload_length != 8'd0)
                begin
                    nxt.phase = PH_DATA;
                end
                else if (cfg.trailer_bytes != 3'd0)
                begin
                    nxt.phase = PH_TRAIL;
                end
                else
                begin
                    res.valid = 1'b1;
                    nxt.phase = PH_HUNT1;
                end
            end
            PH_DATA:
            begin
                res.valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.byte_index   = cur.position;
                res.last         = fin;
                if (fin)
                begin
                    if (cfg.trailer_bytes != 3'd0)
                    begin
                        nxt.position = 8'd0;
                        nxt.phase    = PH_TRAIL;
                    end
                    else
                    begin
                        nxt.phase = PH_PEND;
                    end
                end
                else
                begin
                    nxt.position = pos_inc;
                end
            end
            PH_TRAIL:
            begin
                nxt.position = pos_inc;
                if (trail_done)
                begin
                    res.valid = 1'b1;
                    nxt.phase = PH_HUNT1;
                end
            end
            PH_PEND:
            begin
                res.valid = 1'b1;
                nxt.phase = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
            default:
            begin
                nxt.phase = (rx_byte == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

endmodule

/* src/sync_length_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_unit
// two-byte sync, length-prefixed frame deframer with streaming payload output
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and delivers each payload byte, tagged
// with frame id, index and last flag, followed by a frame-complete word once
// the trailer bytes have been skipped (with no trailer, on the next byte, or
// on the id byte when the length is zero). The phase logic feeds a one-deep
// output register, so the sustained rate is one byte per clock; input stall
// follows only output back-pressure while a word is held in that register.
module sync_length_frame_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] frame_id,
    output logic [7:0] payload_byte,
    output logic [7:0] byte_index,
    output logic       last
);
    import sld_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    out_valid_reg;
    logic    kind_reg;
    logic    last_reg;
    logic [7:0] frame_id_reg;
    logic [7:0] payload_byte_reg;
    logic [7:0] byte_index_reg;
    logic    in_accept;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    sld_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .rx_byte (rx_byte),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= SYNC_FIRST_RST;
            cfg_reg.sync_second   <= SYNC_SECOND_RST;
            cfg_reg.trailer_bytes <= TRAILER_BYTES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:    cfg_reg.sync_first    <= cfg_data;
                REG_SYNC_SECOND:   cfg_reg.sync_second   <= cfg_data;
                REG_TRAILER_BYTES: cfg_reg.trailer_bytes <= cfg_data[2:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_HUNT1;
            state_reg.current_id     <= 8'd0;
            state_reg.payload_length <= 8'd0;
            state_reg.position       <= 8'd0;
            out_valid_reg            <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= res_next.valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_next.valid)
        begin
            kind_reg         <= res_next.kind;
            frame_id_reg     <= res_next.frame_id;
            payload_byte_reg <= res_next.payload_byte;
            byte_index_reg   <= res_next.byte_index;
            last_reg         <= res_next.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign frame_id     = frame_id_reg;
    assign payload_byte = payload_byte_reg;
    assign byte_index   = byte_index_reg;
    assign last         = last_reg;

endmodule

/* src/sld_checker.sv */
// ----------------------------------------------------------------------------
// sld_checker
// port-level checks for the deframer, bound to the top level
// ----------------------------------------------------------------------------
module sld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic [7:0] payload_byte,
    input logic       last
);
    import sld_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    a_complete_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_COMPLETE |-> payload_byte == 8'd0 && !last)
        else $error("frame-complete word carries payload or last");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
        else $error("output word repeated");

endmodule

bind sync_length_frame_deframer_unit sld_checker u_sld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last)
);

/* sim/sync_length_frame_deframer_checker.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_checker
// watches the deframer ports, predicts every output word and compares them
// ----------------------------------------------------------------------------
// Follows register writes and accepted input bytes with its own copy of the
// deframer state, queues the word each byte should produce and checks every
// accepted output word, field by field, against the oldest queued word.
// Words still queued when end_of_test rises are counted as one failure.
module sync_length_frame_deframer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [7:0]  frame_id,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  byte_index,
    input  logic        last,
    input  logic        end_of_test,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output int unsigned payload_words,
    output int unsigned complete_words
);
    import sld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_id;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last;
    } frame_word_t;

    cfg_t        cfg;
    state_t      st;
    frame_word_t expected_words[$];
    logic        drain_reported;

    function automatic frame_word_t complete_word();
        frame_word_t w;
        w.kind         = KIND_COMPLETE;
        w.frame_id     = st.current_id;
        w.payload_byte = 8'd0;
        w.byte_index   = st.payload_length;
        w.last         = 1'b0;
        return w;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        frame_word_t w;
        logic        fin;
        case (st.phase)
            PH_HUNT2:
            begin
                if (b == cfg.sync_second)
                    st.phase = PH_LEN;
                else if (b == cfg.sync_first)
                    st.phase = PH_HUNT2;
                else
                    st.phase = PH_HUNT1;
            end
            PH_LEN:
            begin
                st.payload_length = b;
                st.phase = PH_ID;
            end
            PH_ID:
            begin
                st.current_id = b;
                st.position = 8'd0;
                if (st.payload_length != 8'd0)
                    st.phase = PH_DATA;
                else if (cfg.trailer_bytes != 3'd0)
                    st.phase = PH_TRAIL;
                else
                begin
                    expected_words.push_back(complete_word());
                    st.phase = PH_HUNT1;
                end
            end
            PH_DATA:
            begin
                fin = (8'(st.position + 8'd1) == st.payload_length) ||
                      (st.position >= st.payload_length);
                w.kind         = KIND_PAYLOAD;
                w.frame_id     = st.current_id;
                w.payload_byte = b;
                w.byte_index   = st.position;
                w.last         = fin;
                expected_words.push_back(w);
                if (!fin)
                    st.position = st.position + 8'd1;
                else if (cfg.trailer_bytes != 3'd0)
                begin
                    st.position = 8'd0;
                    st.phase = PH_TRAIL;
                end
                else
                    st.phase = PH_PEND;
            end
            PH_TRAIL:
            begin
                st.position = st.position + 8'd1;
                if (st.position >= {5'd0, cfg.trailer_bytes})
                begin
                    expected_words.push_back(complete_word());
                    st.phase = PH_HUNT1;
                end
            end
            PH_PEND:
            begin
                expected_words.push_back(complete_word());
                st.phase = (b == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
            default:
            begin
                st.phase = (b == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    initial
    begin
        mismatches     = 0;
        payload_words  = 0;
        complete_words = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t w;
        if (!rst_n)
        begin
            cfg.sync_first    = SYNC_FIRST_RST;
            cfg.sync_second   = SYNC_SECOND_RST;
            cfg.trailer_bytes = TRAILER_BYTES_RST;
            st.phase          = PH_HUNT1;
            st.current_id     = 8'd0;
            st.payload_length = 8'd0;
            st.position       = 8'd0;
            expected_words.delete();
            drain_reported    = 1'b0;
            outstanding      <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SYNC_FIRST:    cfg.sync_first    = cfg_data;
                    REG_SYNC_SECOND:   cfg.sync_second   = cfg_data;
                    REG_TRAILER_BYTES: cfg.trailer_bytes = cfg_data[2:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("word with nothing expected: kind %0d id 'h%0h data 'h%0h",
                           kind, frame_id, payload_byte);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    w = expected_words.pop_front();
                    check_field("kind", {7'd0, w.kind}, {7'd0, kind});
                    check_field("frame_id", w.frame_id, frame_id);
                    check_field("payload_byte", w.payload_byte, payload_byte);
                    check_field("byte_index", w.byte_index, byte_index);
                    check_field("last", {7'd0, w.last}, {7'd0, last});
                    if (w.kind == KIND_COMPLETE)
                        complete_words = complete_words + 1;
                    else
                        payload_words = payload_words + 1;
                end
            end
            if (end_of_test && !drain_reported)
            begin
                if (expected_words.size() != 0)
                begin
                    $error("%0d expected words never arrived", expected_words.size());
                    mismatches = mismatches + 1;
                end
                drain_reported = 1'b1;
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

/* sim/sync_length_frame_deframer_unit_tb.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_unit_tb
// byte stream stimulus and verdict for the sync/length frame deframer
// ----------------------------------------------------------------------------
// Feeds directed frames (extreme bytes, repeated first sync, zero length,
// no trailer, trailer shortened mid-frame) and then mostly well-formed random
// frames mixed with noise and broken syncs, over several register settings.
// Both channels idle at random; the checker beside the block does the
// prediction and comparison and reports its failure count here.
module sync_length_frame_deframer_unit_tb;
    import sld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = REG_SYNC_FIRST;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] frame_id;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       end_of_test = 1'b0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned payload_words;
    int unsigned complete_words;

    logic        quiet = 1'b0;
    logic [7:0]  cur_sync_first  = SYNC_FIRST_RST;
    logic [7:0]  cur_sync_second = SYNC_SECOND_RST;
    logic [2:0]  cur_trailer     = TRAILER_BYTES_RST;
    int unsigned bytes_sent    = 0;
    int unsigned settings_seen = 1;

    sync_length_frame_deframer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .frame_id     (frame_id),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last)
    );

    sync_length_frame_deframer_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .frame_id       (frame_id),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .last           (last),
        .end_of_test    (end_of_test),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .payload_words  (payload_words),
        .complete_words (complete_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 28);

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int unsigned len);
        send_byte(cur_sync_first);
        send_byte(cur_sync_second);
        send_byte(len[7:0]);
        send_byte(8'($urandom));
        repeat (len) send_byte(8'($urandom));
        repeat (cur_trailer) send_byte(8'($urandom));
    endtask

    // wait until every expected word is out and the output register is empty
    task automatic settle();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] sf, input logic [7:0] ss,
                                 input logic [2:0] tr);
        logic [4:0] upper;
        upper = 5'($urandom);
        write_reg(REG_SYNC_FIRST, sf);
        write_reg(REG_SYNC_SECOND, ss);
        write_reg(REG_TRAILER_BYTES, {upper, tr});
        write_reg(REG_SPARE, 8'($urandom));
        cfg_write <= 1'b0;
        cur_sync_first  = sf;
        cur_sync_second = ss;
        cur_trailer     = tr;
        settings_seen++;
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned phase_end;
        logic [7:0]  sf;
        logic [7:0]  ss;
        logic [2:0]  tr;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extreme payload bytes, broken sync, repeated first sync
        send_byte(8'h7E); send_byte(8'h7F); send_byte(8'h02); send_byte(8'h55);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h7E);
        send_byte(8'h7E); send_byte(8'h12);
        send_byte(8'h7E); send_byte(8'h7E); send_byte(8'h7F); send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h5A); send_byte(8'hA5); send_byte(8'h3C);
        settle();

        // no trailer: completion rides on the next byte, zero length on the id
        load_settings(8'h7E, 8'h7F, 3'd0);
        send_byte(8'h7E); send_byte(8'h7F); send_byte(8'h01); send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7E); send_byte(8'h7F); send_byte(8'h00); send_byte(8'hFF);
        settle();

        // trailer register lowered while the trailer is being skipped
        load_settings(8'h7E, 8'h7F, 3'd5);
        send_byte(8'h7E); send_byte(8'h7F); send_byte(8'h01); send_byte(8'h33);
        send_byte(8'h44); send_byte(8'h99);
        settle();
        write_reg(REG_TRAILER_BYTES, 8'h01);
        cfg_write <= 1'b0;
        cur_trailer = 3'd1;
        send_byte(8'h66);
        settle();

        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: begin sf = 8'h00; ss = 8'hFF; tr = 3'd7; end
                1: begin sf = 8'hFF; ss = 8'h00; tr = 3'd0; end
                2: begin sf = 8'hA5; ss = 8'hA5; tr = 3'd1; end
                5: begin sf = SYNC_FIRST_RST; ss = SYNC_SECOND_RST; tr = TRAILER_BYTES_RST; end
                default:
                begin
                    sf = 8'($urandom);
                    ss = 8'($urandom);
                    tr = 3'($urandom);
                end
            endcase
            load_settings(sf, ss, tr);
            quiet = (s == 2);
            if (s == 3)
                send_frame(255);
            phase_end = bytes_sent + 30;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                else if (pick == 1)
                begin
                    send_byte(cur_sync_first);
                    send_byte(8'($urandom));
                end
                else if (pick == 2)
                    send_frame($urandom_range(9, 40));
                else
                    send_frame($urandom_range(0, 8));
            end
            settle();
        end
        quiet = 1'b0;

        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        $display("run fed %0d bytes across %0d register settings",
                 bytes_sent, settings_seen);
        $display("checked %0d payload words and %0d frame completions",
                 payload_words, complete_words);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
